// ===== hw/rtl/text_cell_cursor_renderer_macros.svh =====
// ----------------------------------------------------------------------------
// text cell cursor renderer assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_CURSOR_RENDERER_MACROS_SVH
`define TEXT_CELL_CURSOR_RENDERER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define TCCR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tccr check failed");

// condition never holds
`define TCCR_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tccr check failed");

`else

`define TCCR_ASSERT_IMP(lbl, ante, cons)
`define TCCR_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== hw/rtl/tccr_pkg.sv =====
// ----------------------------------------------------------------------------
// tccr_pkg
// shared constants for the text cell cursor renderer
// ----------------------------------------------------------------------------
package tccr_pkg;

    // video ram window, a power of two
    localparam int VRAM_SPAN  = 2048;
    localparam int GLYPH_ROWS = 16;
    localparam int FONT_DEPTH = 4096;

    localparam int REL_W   = $clog2(VRAM_SPAN);
    localparam int FONT_AW = $clog2(FONT_DEPTH);

    // configuration register indexes
    localparam logic [2:0] CFG_RAM_OFFSET   = 3'd0;
    localparam logic [2:0] CFG_SCREEN_COLS  = 3'd1;
    localparam logic [2:0] CFG_SCREEN_ROWS  = 3'd2;
    localparam logic [2:0] CFG_CELL_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_CELL_HEIGHT  = 3'd4;
    localparam logic [2:0] CFG_SCALE        = 3'd5;
    localparam logic [2:0] CFG_CURSOR_START = 3'd6;
    localparam logic [2:0] CFG_CURSOR_END   = 3'd7;

    // input item commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

endpackage

// ===== hw/rtl/tccr_divider.sv =====
// ----------------------------------------------------------------------------
// tccr_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tccr_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tccr_pkg::REL_W-1:0] dividend,
    input  logic [7:0]                divisor,
    output logic                      done,
    output logic [tccr_pkg::REL_W-1:0] quotient,
    output logic [7:0]                remainder
);
    import tccr_pkg::*;

    localparam int CNT_W = $clog2(REL_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [REL_W-1:0] quo_reg;
    logic [7:0]       rem_reg;
    logic [8:0]       trial;
    logic [8:0]       diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[REL_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = trial >= {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(REL_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[7:0] : trial[7:0];
            quo_reg <= {quo_reg[REL_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/text_cell_cursor_renderer.sv =====
// ----------------------------------------------------------------------------
// text_cell_cursor_renderer
// character cell renderer with block cursor over a font memory
// ----------------------------------------------------------------------------
//
// channel   direction  fields
// s_axis    in         tuser cmd, tdata address/char_code/cursor_address/blink
// m_axis    out        tuser off_screen, tdata cell coords and pixels, tlast
// cfg       in         cfg_index, cfg_data, always ready
//
// a load item writes the font memory at acceptance
// after acceptance a render item runs the bit-serial divider (11 quotient bits
// and the done flag) and a setup state, then gives one result per cycle while
// the output register is free (height times 1 or 2, a single result when off
// screen or zero height); the font memory has a single read port
// render items are taken one at a time; the next item is accepted while the
// last result still waits in the output register
// reset clears control and restores register defaults; the font memory has
// no reset and no clearing pass
//
module text_cell_cursor_renderer
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[15:0], char_code[23:16], cursor_address[39:24], blink_phase[40], zero pad
    input  logic [tccr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic        s_axis_tuser,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cell_col[6:0], cell_row[12:7], left_px[24:13], top_px[36:25],
    // line_index[41:37], pixel_row[73:42], zero pad
    output logic [tccr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // off_screen
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tccr_pkg::*;

`include "text_cell_cursor_renderer_macros.svh"

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SETUP = 2'd2;
    localparam logic [1:0] ST_LINE  = 2'd3;

    // configuration registers
    logic [15:0] ram_offset_reg;
    logic [7:0]  screen_cols_reg;
    logic [6:0]  screen_rows_reg;
    logic [3:0]  cell_width_reg;
    logic [4:0]  cell_height_reg;
    logic [1:0]  scale_reg;
    logic [6:0]  cursor_start_reg;
    logic [3:0]  cursor_end_reg;

    // font memory
    logic [7:0]         font_mem [FONT_DEPTH];
    logic [7:0]         font_rdata_reg;
    logic               mem_we;
    logic               mem_re;
    logic [FONT_AW-1:0] mem_raddr;

    // sequencer
    logic [1:0]  state_reg, state_next;
    logic [7:0]  code_reg, code_next;
    logic        hit_reg, hit_next;
    logic        off_reg, off_next;
    logic [3:0]  w_reg, w_next;
    logic [4:0]  h_reg, h_next;
    logic        dbl_reg, dbl_next;
    logic [11:0] left_reg, left_next;
    logic [11:0] top_reg, top_next;
    logic [3:0]  yn_reg, yn_next;
    logic        rep_reg, rep_next;

    // output register
    logic        ovalid_reg, ovalid_next;
    logic        ooff_reg, ooff_next;
    logic [6:0]  ocol_reg, ocol_next;
    logic [5:0]  orow_reg, orow_next;
    logic [11:0] oleft_reg, oleft_next;
    logic [11:0] otop_reg, otop_next;
    logic [4:0]  oline_reg, oline_next;
    logic [31:0] opix_reg, opix_next;
    logic        olast_reg, olast_next;

    // input fields
    logic [15:0] in_address;
    logic [7:0]  in_char_code;
    logic [15:0] in_cursor_address;
    logic        in_blink_phase;
    logic        in_accept;

    // divider
    logic             div_start;
    logic             div_done;
    logic [REL_W-1:0] div_quo;
    logic [7:0]       div_rem;
    logic [REL_W-1:0] rel;
    logic [15:0]      rel_full;
    logic [7:0]       cols_eff;

    // setup math
    logic [3:0]  w_eff;
    logic [4:0]  h_eff;
    logic [4:0]  cx;
    logic [5:0]  cy;
    logic [31:0] pix_row;
    logic        inv;
    logic        line_final;
    logic        out_free;
    logic [3:0]  bit_idx;

    assign in_address        = s_axis_tdata[15:0];
    assign in_char_code      = s_axis_tdata[23:16];
    assign in_cursor_address = s_axis_tdata[39:24];
    assign in_blink_phase    = s_axis_tdata[40];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !ovalid_reg || m_axis_tready;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_offset_reg   <= 16'd0;
            screen_cols_reg  <= 8'd80;
            screen_rows_reg  <= 7'd24;
            cell_width_reg   <= 4'd8;
            cell_height_reg  <= 5'd8;
            scale_reg        <= 2'd0;
            cursor_start_reg <= 7'd0;
            cursor_end_reg   <= 4'd15;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RAM_OFFSET:   ram_offset_reg   <= cfg_data;
                CFG_SCREEN_COLS:  screen_cols_reg  <= cfg_data[7:0];
                CFG_SCREEN_ROWS:  screen_rows_reg  <= cfg_data[6:0];
                CFG_CELL_WIDTH:   cell_width_reg   <= cfg_data[3:0];
                CFG_CELL_HEIGHT:  cell_height_reg  <= cfg_data[4:0];
                CFG_SCALE:        scale_reg        <= cfg_data[1:0];
                CFG_CURSOR_START: cursor_start_reg <= cfg_data[6:0];
                CFG_CURSOR_END:   cursor_end_reg   <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // address split: offset removal, wrap, then column/row divide
    // ------------------------------------------------------------------
    assign rel_full  = in_address - ram_offset_reg;
    assign rel       = rel_full[REL_W-1:0];
    // zero columns behaves as one column
    assign cols_eff  = (screen_cols_reg == 8'd0) ? 8'd1 : screen_cols_reg;
    assign div_start = in_accept && (s_axis_tuser == CMD_RENDER);

    tccr_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rel),
        .divisor   (cols_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // font memory, one write and one registered read port
    // ------------------------------------------------------------------
    assign mem_we = in_accept && (s_axis_tuser == CMD_LOAD);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            font_mem[in_address[FONT_AW-1:0]] <= in_char_code;
        if (mem_re)
            font_rdata_reg <= font_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // cell geometry: width made even and capped at 8, height capped at 16
    // ------------------------------------------------------------------
    assign w_eff = cell_width_reg[3] ? 4'd8 : {cell_width_reg[2:1], 1'b0} | 4'd0;
    assign h_eff = cell_height_reg[4] ? 5'd16 : cell_height_reg;
    assign cx    = scale_reg[0] ? {w_eff, 1'b0} : {1'b0, w_eff};
    assign cy    = scale_reg[1] ? {h_eff, 1'b0} : {1'b0, h_eff};

    // scanline inversion inside the cursor band
    assign inv = hit_reg && (yn_reg >= cursor_start_reg[3:0]) && (yn_reg <= cursor_end_reg);
    assign line_final = (({1'b0, yn_reg} + 5'd1) == h_reg) && (rep_reg == dbl_reg);

    // pixels msb of the font byte first, first pixel in the highest used nibble
    always_comb
    begin
        pix_row = '0;
        bit_idx = '0;
        for (int k = 0; k < 8; k++)
        begin
            bit_idx = 4'(8 + k) - w_reg;
            if (4'(k) < w_reg)
                pix_row[4*k +: 4] = {4{font_rdata_reg[bit_idx[2:0]] ^ inv}};
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        code_next   = code_reg;
        hit_next    = hit_reg;
        off_next    = off_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        dbl_next    = dbl_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        yn_next     = yn_reg;
        rep_next    = rep_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        ooff_next   = ooff_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        oleft_next  = oleft_reg;
        otop_next   = otop_reg;
        oline_next  = oline_reg;
        opix_next   = opix_reg;
        olast_next  = olast_reg;
        mem_re      = 1'b0;
        mem_raddr   = FONT_AW'(int'(code_reg) * GLYPH_ROWS + int'(yn_reg));

        case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                begin
                    code_next  = in_char_code;
                    // cursor match ignores the ram offset
                    hit_next   = (in_address[REL_W-1:0] == in_cursor_address[REL_W-1:0])
                                 && (in_blink_phase || !cursor_start_reg[6]);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                off_next   = div_quo >= REL_W'(screen_rows_reg);
                w_next     = w_eff;
                h_next     = h_eff;
                dbl_next   = scale_reg[1];
                left_next  = 12'(div_rem * cx);
                top_next   = 12'(div_quo * cy);
                yn_next    = '0;
                rep_next   = 1'b0;
                // first scanline read, data lands for the line state
                mem_re     = 1'b1;
                mem_raddr  = FONT_AW'(int'(code_reg) * GLYPH_ROWS);
                state_next = ST_LINE;
            end
            ST_LINE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ooff_next   = off_reg;
                    if (off_reg)
                    begin
                        // row below the screen: one empty result
                        ocol_next  = '0;
                        orow_next  = '0;
                        oleft_next = '0;
                        otop_next  = '0;
                        oline_next = '0;
                        opix_next  = '0;
                        olast_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ocol_next  = div_rem[6:0];
                        orow_next  = div_quo[5:0];
                        oleft_next = left_reg;
                        otop_next  = top_reg;
                        if (h_reg == 5'd0)
                        begin
                            // zero height cell: coordinates only
                            oline_next = '0;
                            opix_next  = '0;
                            olast_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            oline_next = dbl_reg ? {yn_reg, rep_reg} : {1'b0, yn_reg};
                            opix_next  = pix_row;
                            olast_next = line_final;
                            if (dbl_reg && !rep_reg)
                                rep_next = 1'b1;
                            else if (line_final)
                                state_next = ST_IDLE;
                            else
                            begin
                                rep_next  = 1'b0;
                                yn_next   = yn_reg + 4'd1;
                                mem_re    = 1'b1;
                                mem_raddr = FONT_AW'(int'(code_reg) * GLYPH_ROWS
                                                     + int'(yn_reg) + 1);
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        hit_reg   <= hit_next;
        off_reg   <= off_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        dbl_reg   <= dbl_next;
        left_reg  <= left_next;
        top_reg   <= top_next;
        yn_reg    <= yn_next;
        rep_reg   <= rep_next;
        ooff_reg  <= ooff_next;
        ocol_reg  <= ocol_next;
        orow_reg  <= orow_next;
        oleft_reg <= oleft_next;
        otop_reg  <= otop_next;
        oline_reg <= oline_next;
        opix_reg  <= opix_next;
        olast_reg <= olast_next;
    end

    // ------------------------------------------------------------------
    // result port
    // ------------------------------------------------------------------
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = ooff_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {6'd0, opix_reg, oline_reg, otop_reg, oleft_reg,
                            orow_reg, ocol_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // an off-screen result always closes its render item
    `TCCR_ASSERT_IMP(a_off_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    // divider finishes only while the sequencer waits for it
    `TCCR_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == ST_DIV)
    // a font load never meets a glyph read in the same cycle
    `TCCR_ASSERT_NEVER(a_no_rw_overlap, mem_we && mem_re)

endmodule

// ===== bench/text_cell_cursor_renderer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_cell_cursor_renderer_tb
// self-checking bench for the character cell renderer with block cursor
// ----------------------------------------------------------------------------
//
// a short table of hand-picked items and register writes runs first, then
// eight phases of register settings, six random, two fixed, each followed
// by random font loads and render items. every accepted render is run through
// a local model of the cell drawing, and each result item is compared field
// by field with the oldest predicted scanline. glyphs are always loaded
// before a render can read them, since the font memory has no reset.
//
module text_cell_cursor_renderer_tb;

    import tccr_pkg::*;

    localparam int IDLE_PCT        = 21;    // chance per cycle that a side idles
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 48;    // random items per register setting
    localparam int DRAIN_CYCLES    = 32;    // divider plus setup, with margin
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int PLAN_LEN        = 35;

    // one output scanline of a cell, as the block reports it
    typedef struct packed {
        logic        off_screen;
        logic [6:0]  cell_col;
        logic [5:0]  cell_row;
        logic [11:0] left_px;
        logic [11:0] top_px;
        logic [4:0]  line_index;
        logic [31:0] pixel_row;
        logic        last;
    } cell_line_t;

    localparam cell_line_t OFF_SCREEN_LINE =
        '{1'b1, 7'd0, 6'd0, 12'd0, 12'd0, 5'd0, 32'd0, 1'b1};

    typedef enum logic [1:0] {ROW_LOAD, ROW_RENDER, ROW_CFG} row_kind_e;

    // directed table row; for register writes addr carries the write data
    typedef struct {
        row_kind_e   kind;
        logic [2:0]  reg_idx;
        logic [15:0] addr;
        logic [7:0]  code;
        logic [15:0] cur;
        logic        blink;
        bit          typed;     // expect a single off-screen item
    } plan_row_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [15:0]           cfg_data  = '0;

    // shadow of the register file, at the register widths
    logic [15:0] r_offset    = 16'd0;
    logic [7:0]  r_cols      = 8'd80;
    logic [6:0]  r_rows      = 7'd24;
    logic [3:0]  r_width     = 4'd8;
    logic [4:0]  r_height    = 5'd8;
    logic [1:0]  r_scale     = 2'd0;
    logic [6:0]  r_cur_start = 7'd0;
    logic [3:0]  r_cur_end   = 4'd15;

    // shadow font memory; only written entries are ever read
    logic [7:0] glyph_mem [FONT_DEPTH];
    bit         glyph_set [FONT_DEPTH];
    bit         glyph_ready [256];
    logic [7:0] ready_codes [$];

    cell_line_t pending_lines [$];

    bit calm = 1'b0;    // both sides stream without idling
    int n_items, n_renders, n_lines, n_fail, n_settings;
    int quiet_cycles;

    plan_row_t plan [PLAN_LEN] = '{
        // font bytes at the address extremes, plus one aliased write
        '{ROW_LOAD,   '0,               16'h0000, 8'h00, 16'h0000, 1'b0, 1'b0},
        '{ROW_LOAD,   '0,               16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b0},
        '{ROW_LOAD,   '0,               16'h1001, 8'h81, 16'h0000, 1'b0, 1'b0},
        // cursor matches modulo the video ram span, no blinking: whole cell inverted
        '{ROW_RENDER, '0,               16'h0000, 8'h00, 16'h0800, 1'b0, 1'b0},
        // rows 25 and 24 lie below an 80 x 24 screen
        '{ROW_RENDER, '0,               16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1},
        '{ROW_RENDER, '0,               16'd1920, 8'h41, 16'h0000, 1'b0, 1'b1},
        '{ROW_RENDER, '0,               16'd1919, 8'hFF, 16'h0000, 1'b1, 1'b0},
        // blinking cursor on scanlines 3 to 5
        '{ROW_CFG,    CFG_CURSOR_START, 16'h0043, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_CURSOR_END,   16'h0005, '0,    '0,       '0,   '0},
        '{ROW_RENDER, '0,               16'h0005, 8'h00, 16'hF805, 1'b0, 1'b0},
        '{ROW_RENDER, '0,               16'h0005, 8'h41, 16'h0805, 1'b1, 1'b0},
        // offset wraps, zero columns, wide odd and tall cell, both doublings
        '{ROW_CFG,    CFG_RAM_OFFSET,   16'hFFFF, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_SCREEN_COLS,  16'h0000, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_SCALE,        16'h0003, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_CELL_WIDTH,   16'h000F, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_CELL_HEIGHT,  16'h001F, '0,    '0,       '0,   '0},
        '{ROW_RENDER, '0,               16'hFFFF, 8'h41, 16'h0000, 1'b0, 1'b0},
        '{ROW_RENDER, '0,               16'h0016, 8'hFF, 16'h0016, 1'b1, 1'b0},
        '{ROW_RENDER, '0,               16'h0017, 8'h00, 16'h0000, 1'b0, 1'b1},
        // zero height, then a width that rounds to no pixels
        '{ROW_CFG,    CFG_RAM_OFFSET,   16'h0000, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_SCREEN_COLS,  16'h00FF, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_SCREEN_ROWS,  16'h007F, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_CELL_HEIGHT,  16'h0000, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_CELL_WIDTH,   16'h0001, '0,    '0,       '0,   '0},
        '{ROW_RENDER, '0,               16'h07FF, 8'h80, 16'h0000, 1'b0, 1'b0},
        '{ROW_CFG,    CFG_CELL_HEIGHT,  16'h0001, '0,    '0,       '0,   '0},
        '{ROW_RENDER, '0,               16'h0100, 8'h80, 16'h0100, 1'b1, 1'b0},
        // cursor range start after end, so nothing inverts
        '{ROW_CFG,    CFG_CELL_WIDTH,   16'h0002, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_CELL_HEIGHT,  16'h0010, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_SCALE,        16'h0000, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_CURSOR_START, 16'h007F, '0,    '0,       '0,   '0},
        '{ROW_CFG,    CFG_CURSOR_END,   16'h0000, '0,    '0,       '0,   '0},
        '{ROW_RENDER, '0,               16'h07FF, 8'hFF, 16'hFFFF, 1'b1, 1'b0},
        // no rows shown at all
        '{ROW_CFG,    CFG_SCREEN_ROWS,  16'h0000, '0,    '0,       '0,   '0},
        '{ROW_RENDER, '0,               16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1}
    };

    text_cell_cursor_renderer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // register write as the block sees it: upper data bits are dropped
    task automatic apply_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_RAM_OFFSET:   r_offset    = data;
            CFG_SCREEN_COLS:  r_cols      = data[7:0];
            CFG_SCREEN_ROWS:  r_rows      = data[6:0];
            CFG_CELL_WIDTH:   r_width     = data[3:0];
            CFG_CELL_HEIGHT:  r_height    = data[4:0];
            CFG_SCALE:        r_scale     = data[1:0];
            CFG_CURSOR_START: r_cur_start = data[6:0];
            default:          r_cur_end   = data[3:0];
        endcase
    endtask

    function automatic int unsigned reg_bits(input logic [2:0] idx);
        case (idx)
            CFG_RAM_OFFSET:   return 16;
            CFG_SCREEN_COLS:  return 8;
            CFG_SCREEN_ROWS:  return 7;
            CFG_CELL_WIDTH:   return 4;
            CFG_CELL_HEIGHT:  return 5;
            CFG_SCALE:        return 2;
            CFG_CURSOR_START: return 7;
            default:          return 4;
        endcase
    endfunction

    // queue the scanlines that one render item should produce
    task automatic draw_cell(input logic [15:0] addr, input logic [7:0] code,
                             input logic [15:0] cur, input logic blink);
        logic [15:0] diff;
        int unsigned rel, cols, col, row, w, h, cx, reps, ys, ye, idx;
        logic [7:0]  bits;
        logic [31:0] pix;
        bit          hit, inv;
        cell_line_t  ln;
        diff = addr - r_offset;
        rel  = diff % VRAM_SPAN;
        cols = (r_cols == 0) ? 1 : r_cols;
        col  = rel % cols;
        row  = rel / cols;
        if (row >= r_rows)
        begin
            pending_lines.push_back(OFF_SCREEN_LINE);
            return;
        end
        // pixel count is even and at most 8, height at most 16
        w = 32'({r_width[3:1], 1'b0});
        if (w > 8)
            w = 8;
        h    = (r_height > 16) ? 16 : r_height;
        cx   = r_scale[0] ? 2 * w : w;
        reps = r_scale[1] ? 2 : 1;
        ln            = '0;
        ln.cell_col   = col[6:0];
        ln.cell_row   = row[5:0];
        ln.left_px    = 12'(col * cx);
        ln.top_px     = 12'(row * h * reps);
        if (h == 0)
        begin
            ln.last = 1'b1;
            pending_lines.push_back(ln);
            return;
        end
        // cursor compares raw addresses in the ram window, offset not applied
        ys  = 32'(r_cur_start[3:0]);
        ye  = 32'(r_cur_end);
        hit = ((addr % VRAM_SPAN) == (cur % VRAM_SPAN)) && (blink || !r_cur_start[6]);
        for (int unsigned yn = 0; yn < h; yn++)
        begin
            idx  = (code * GLYPH_ROWS + yn) % FONT_DEPTH;
            bits = glyph_mem[idx];
            inv  = hit && (yn >= ys) && (yn <= ye);
            pix  = '0;
            for (int unsigned i = 0; i < w; i++)
                pix = (pix << 4) | ((bits[7 - i] ^ inv) ? 32'hF : 32'h0);
            for (int unsigned rep = 0; rep < reps; rep++)
            begin
                ln.line_index = 5'(yn * reps + rep);
                ln.pixel_row  = pix;
                ln.last       = (yn + 1 == h) && (rep + 1 == reps);
                pending_lines.push_back(ln);
            end
        end
    endtask

    // valid stays high after acceptance until the next item or a pause
    task automatic send_item(input logic cmd, input logic [15:0] addr,
                             input logic [7:0] code, input logic [15:0] cur,
                             input logic blink, input bit typed);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, blink, cur, code, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_items++;
        if (cmd == CMD_LOAD)
        begin
            glyph_mem[addr % FONT_DEPTH] = code;
            glyph_set[addr % FONT_DEPTH] = 1'b1;
        end
        else
        begin
            n_renders++;
            if (typed)
                pending_lines.push_back(OFF_SCREEN_LINE);
            else
                draw_cell(addr, code, cur, blink);
        end
    endtask

    // load whatever rows of a glyph are still unwritten, with random content
    task automatic ensure_glyph(input logic [7:0] code);
        logic [11:0] idx;
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            idx = 12'(code * GLYPH_ROWS + r);
            if (!glyph_set[idx])
                send_item(CMD_LOAD, {4'($urandom), idx}, 8'($urandom), 16'($urandom),
                          1'($urandom), 1'b0);
        end
        if (!glyph_ready[code])
        begin
            glyph_ready[code] = 1'b1;
            ready_codes.push_back(code);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    // stop sending, wait out every result, then let the block go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    // result side stalls at random except in the calm phase
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // compare each accepted result item with the oldest prediction
    always @(posedge clk)
    begin : result_check
        cell_line_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            // tdata: cell_col, cell_row, left_px, top_px, line_index, pixel_row
            got = {m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[12:7],
                   m_axis_tdata[24:13], m_axis_tdata[36:25], m_axis_tdata[41:37],
                   m_axis_tdata[73:42], m_axis_tlast};
            if (pending_lines.size() == 0)
            begin
                $error("result item with nothing expected");
                n_fail++;
            end
            else
            begin
                want = pending_lines.pop_front();
                n_lines++;
                check_field("off_screen", want.off_screen, got.off_screen);
                check_field("cell_col",   want.cell_col,   got.cell_col);
                check_field("cell_row",   want.cell_row,   got.cell_row);
                check_field("left_px",    want.left_px,    got.left_px);
                check_field("top_px",     want.top_px,     got.top_px);
                check_field("line_index", want.line_index, got.line_index);
                check_field("pixel_row",  want.pixel_row,  got.pixel_row);
                check_field("last",       want.last,       got.last);
            end
        end
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d cycles without a handshake", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned visible, cols;
        int          stop_at;
        logic [7:0]  code;
        logic [15:0] addr, cur;
        logic [15:0] v [8];
        bit          cfg_open;

        cfg_open = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; register rows are grouped and written while idle
        for (int k = 0; k < PLAN_LEN; k++)
        begin
            if (plan[k].kind == ROW_CFG)
            begin
                if (!cfg_open)
                begin
                    settle();
                    cfg_open = 1'b1;
                end
                write_reg(plan[k].reg_idx, plan[k].addr);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open  = 1'b0;
                    n_settings++;
                end
                if (plan[k].kind == ROW_RENDER)
                    ensure_glyph(plan[k].code);
                send_item((plan[k].kind == ROW_LOAD) ? CMD_LOAD : CMD_RENDER, plan[k].addr,
                          plan[k].code, plan[k].cur, plan[k].blink, plan[k].typed);
            end
        end

        // phases of random items: first one streams with no idling on either side
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            calm = (phase == 0);
            case (phase)
                1:
                begin
                    // smallest screen and cell
                    v[CFG_RAM_OFFSET]   = 16'h0000;
                    v[CFG_SCREEN_COLS]  = 16'd1;
                    v[CFG_SCREEN_ROWS]  = 16'd1;
                    v[CFG_CELL_WIDTH]   = 16'd2;
                    v[CFG_CELL_HEIGHT]  = 16'd1;
                    v[CFG_SCALE]        = 16'd0;
                    v[CFG_CURSOR_START] = 16'h0000;
                    v[CFG_CURSOR_END]   = 16'd0;
                end
                2:
                begin
                    // largest screen and cell, blinking cursor on the last line
                    v[CFG_RAM_OFFSET]   = 16'hFFFF;
                    v[CFG_SCREEN_COLS]  = 16'd128;
                    v[CFG_SCREEN_ROWS]  = 16'd64;
                    v[CFG_CELL_WIDTH]   = 16'd8;
                    v[CFG_CELL_HEIGHT]  = 16'd16;
                    v[CFG_SCALE]        = 16'd3;
                    v[CFG_CURSOR_START] = 16'h004F;
                    v[CFG_CURSOR_END]   = 16'd15;
                end
                default:
                begin
                    // mostly sane values, now and then anything the field holds
                    v[CFG_RAM_OFFSET]   = 16'($urandom);
                    v[CFG_SCREEN_COLS]  = 16'(($urandom_range(3) != 0) ? $urandom_range(1, 128)
                                                                      : $urandom_range(0, 255));
                    v[CFG_SCREEN_ROWS]  = 16'(($urandom_range(3) != 0) ? $urandom_range(1, 64)
                                                                      : $urandom_range(0, 127));
                    v[CFG_CELL_WIDTH]   = 16'(($urandom_range(3) != 0)
                                              ? 2 * $urandom_range(1, 4)
                                              : $urandom_range(0, 15));
                    v[CFG_CELL_HEIGHT]  = 16'(($urandom_range(3) != 0) ? $urandom_range(1, 16)
                                                                      : $urandom_range(0, 31));
                    v[CFG_SCALE]        = 16'($urandom_range(0, 3));
                    v[CFG_CURSOR_START] = 16'($urandom_range(0, 127));
                    v[CFG_CURSOR_END]   = 16'($urandom_range(0, 15));
                end
            endcase
            for (int k = CFG_RAM_OFFSET; k <= CFG_CURSOR_END; k++)
            begin
                // stray bits above the register width must be ignored
                if ($urandom_range(3) == 0)
                    v[k] = v[k] | 16'(32'($urandom) << reg_bits(3'(k)));
                write_reg(3'(k), v[k]);
            end
            cfg_valid <= 1'b0;
            n_settings++;

            stop_at = n_items + PHASE_ITEMS;
            while (n_items < stop_at)
            begin
                if ($urandom_range(99) < 12)
                    // stray font write anywhere in the store
                    send_item(CMD_LOAD, 16'($urandom), 8'($urandom), 16'($urandom),
                              1'($urandom), 1'b0);
                else
                begin
                    if (ready_codes.size() != 0 && $urandom_range(7) != 0)
                        code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
                    else
                        code = 8'($urandom);
                    ensure_glyph(code);
                    // aim most renders at visible cells, with random high bits
                    cols    = (r_cols == 0) ? 1 : r_cols;
                    visible = r_rows * cols;
                    if (visible > VRAM_SPAN)
                        visible = VRAM_SPAN;
                    if (visible != 0 && $urandom_range(9) < 7)
                        addr = r_offset + 16'($urandom_range(0, visible - 1))
                               + 16'(VRAM_SPAN * $urandom_range(0, 31));
                    else
                        addr = 16'($urandom);
                    if ($urandom_range(99) < 45)
                        cur = {5'($urandom), addr[10:0]};
                    else
                        cur = 16'($urandom);
                    send_item(CMD_RENDER, addr, code, cur, 1'($urandom), 1'b0);
                end
            end
        end
        calm = 1'b0;

        settle();
        $display("sent %0d input items, %0d of them renders, over %0d register settings",
                 n_items, n_renders, n_settings);
        $display("checked %0d result items, %0d mismatches", n_lines, n_fail);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
